// ----- hdl/ppt_pkg.sv -----
// Shared constants, command and status codes and request type for the priority table
package ppt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned PayloadW   = 32;
  localparam int unsigned PrioW      = 31;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned StatW      = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [PrioW-1:0]  PrioMax = {PrioW{1'b1}};
  localparam logic [CountW-1:0] CountFull = CountW'(TableDepth);

  localparam logic [CmdW-1:0] CmdAdd     = 3'd0;
  localparam logic [CmdW-1:0] CmdPromote = 3'd1;
  localparam logic [CmdW-1:0] CmdRead    = 3'd2;
  localparam logic [CmdW-1:0] CmdIsValid = 3'd3;
  localparam logic [CmdW-1:0] CmdGetMax  = 3'd4;
  localparam logic [CmdW-1:0] CmdPopMax  = 3'd5;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatFull   = 2'd1;
  localparam logic [StatW-1:0] StatEmpty  = 2'd2;
  localparam logic [StatW-1:0] StatUnused = 2'd3;

  typedef enum logic [2:0] {
    OpNone,
    OpAdd,
    OpPromote,
    OpRead,
    OpIsValid,
    OpGetMax,
    OpPopMax
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PayloadW-1:0] payload;
    logic [SlotW-1:0]    slot;
  } req_t;

endpackage

// ----- hdl/ppt_front.sv -----
// Front end: accepts commands and classifies them into queue requests
module ppt_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppt_pkg::CmdW-1:0]      command_i,
  input  logic [ppt_pkg::PayloadW-1:0]  payload_in_i,
  input  logic [ppt_pkg::SlotW-1:0]     slot_in_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ppt_pkg::req_t                 req_o
);

  ppt_pkg::op_e op;

  always_comb begin
    case (command_i)
      ppt_pkg::CmdAdd:     op = ppt_pkg::OpAdd;
      ppt_pkg::CmdPromote: op = ppt_pkg::OpPromote;
      ppt_pkg::CmdRead:    op = ppt_pkg::OpRead;
      ppt_pkg::CmdIsValid: op = ppt_pkg::OpIsValid;
      ppt_pkg::CmdGetMax:  op = ppt_pkg::OpGetMax;
      ppt_pkg::CmdPopMax:  op = ppt_pkg::OpPopMax;
      default:             op = ppt_pkg::OpNone;
    endcase
  end

  assign in_ready_o    = !q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign req_o.op      = op;
  assign req_o.payload = payload_in_i;
  assign req_o.slot    = slot_in_i;

endmodule

// ----- hdl/ppt_queue.sv -----
// Short request queue between the front end and the table engine
module ppt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppt_pkg::req_t req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ppt_pkg::req_t head_o
);

  ppt_pkg::req_t                mem_q [ppt_pkg::QueueDepth];
  logic [ppt_pkg::QPtrW-1:0]    wptr_q, wptr_d;
  logic [ppt_pkg::QPtrW-1:0]    rptr_q, rptr_d;
  logic [ppt_pkg::QCntW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == ppt_pkg::QCntW'(ppt_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == ppt_pkg::QPtrW'(ppt_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == ppt_pkg::QPtrW'(ppt_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= req_i;
    end
  end

endmodule

// ----- hdl/ppt_back.sv -----
// Table engine: entry state, max search tree, payload memory and result register
module ppt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  ppt_pkg::req_t                 q_head_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppt_pkg::SlotW-1:0]     slot_out_o,
  output logic [ppt_pkg::PayloadW-1:0]  payload_out_o,
  output logic [ppt_pkg::PrioW-1:0]     priority_out_o,
  output logic                          occupied_o,
  output logic [ppt_pkg::StatW-1:0]     status_o
);

  localparam int unsigned Depth = ppt_pkg::TableDepth;
  localparam int unsigned SlotW = ppt_pkg::SlotW;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StTree1 = 2'd1;
  localparam logic [1:0] StTree2 = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  typedef struct packed {
    logic                      vld;
    logic [ppt_pkg::PrioW-1:0] prio;
    logic [SlotW-1:0]          rank;
    logic [SlotW-1:0]          idx;
  } cand_t;

  function automatic cand_t pick(cand_t a, cand_t b);
    pick = b;
    if (a.vld && (!b.vld || {a.prio, a.rank} > {b.prio, b.rank})) begin
      pick = a;
    end
  endfunction

  logic [1:0]                   state_q, state_d;
  ppt_pkg::req_t                cur_q;
  logic [Depth-1:0]             used_q, used_d;
  logic [ppt_pkg::CountW-1:0]   count_q, count_d;
  logic [ppt_pkg::PrioW-1:0]    prio_q [Depth];
  logic [SlotW-1:0]             rank_q [Depth];
  logic [ppt_pkg::PayloadW-1:0] pay_mem [Depth];
  logic [ppt_pkg::PayloadW-1:0] rdata_q;
  logic                         mem_re;
  logic [SlotW-1:0]             mem_raddr;
  logic                         mem_we;

  cand_t leaf [Depth];
  cand_t lvl1 [Depth/2];
  cand_t lvl2 [Depth/4];
  cand_t lvl3 [Depth/8];
  cand_t stage1_q [Depth/4];
  cand_t win_q;

  logic [SlotW-1:0]             free_idx;
  logic                         commit;
  logic                         do_promote;
  logic                         do_pop;
  logic [SlotW-1:0]             res_slot;
  logic [ppt_pkg::PayloadW-1:0] res_pay;
  logic [ppt_pkg::PrioW-1:0]    res_prio;
  logic                         res_occ;
  logic [ppt_pkg::StatW-1:0]    res_stat;
  logic                         out_valid_q, out_valid_d;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      leaf[i].vld  = used_q[i];
      leaf[i].prio = prio_q[i];
      leaf[i].rank = rank_q[i];
      leaf[i].idx  = SlotW'(i);
    end
    for (int i = 0; i < Depth/2; i++) begin
      lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < Depth/4; i++) begin
      lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    for (int i = 0; i < Depth/8; i++) begin
      lvl3[i] = pick(stage1_q[2*i], stage1_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    stage1_q <= lvl2;
    win_q    <= pick(lvl3[0], lvl3[1]);
  end

  always_comb begin
    free_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  assign q_pop_o   = (state_q == StIdle) && !q_empty_i;
  assign mem_re    = q_pop_o || (state_q == StTree2);
  assign mem_raddr = (state_q == StTree2) ? win_q.idx : q_head_i.slot;
  assign commit    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          if (q_head_i.op == ppt_pkg::OpGetMax || q_head_i.op == ppt_pkg::OpPopMax) begin
            state_d = StTree1;
          end else begin
            state_d = StDone;
          end
        end
      end
      StTree1: state_d = StTree2;
      StTree2: state_d = StDone;
      StDone: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res_slot   = '0;
    res_pay    = '0;
    res_prio   = '0;
    res_occ    = 1'b0;
    res_stat   = ppt_pkg::StatOk;
    mem_we     = 1'b0;
    do_promote = 1'b0;
    do_pop     = 1'b0;
    case (cur_q.op)
      ppt_pkg::OpAdd: begin
        if (count_q == ppt_pkg::CountFull) begin
          res_stat = ppt_pkg::StatFull;
        end else begin
          res_slot = free_idx;
          mem_we   = 1'b1;
        end
      end
      ppt_pkg::OpPromote: begin
        if (!used_q[cur_q.slot]) begin
          res_stat = ppt_pkg::StatUnused;
        end else begin
          do_promote = (prio_q[cur_q.slot] != ppt_pkg::PrioMax);
        end
      end
      ppt_pkg::OpRead: begin
        if (!used_q[cur_q.slot]) begin
          res_stat = ppt_pkg::StatUnused;
        end else begin
          res_pay = rdata_q;
        end
      end
      ppt_pkg::OpIsValid: res_occ = used_q[cur_q.slot];
      ppt_pkg::OpGetMax, ppt_pkg::OpPopMax: begin
        if (count_q == '0) begin
          res_stat = ppt_pkg::StatEmpty;
        end else begin
          res_slot = win_q.idx;
          res_pay  = rdata_q;
          res_prio = win_q.prio;
          do_pop   = (cur_q.op == ppt_pkg::OpPopMax);
        end
      end
      default: res_stat = ppt_pkg::StatOk;
    endcase
  end

  always_comb begin
    used_d  = used_q;
    count_d = count_q;
    if (commit && mem_we) begin
      used_d[free_idx] = 1'b1;
      count_d          = count_q + 1'b1;
    end else if (commit && do_pop) begin
      used_d[win_q.idx] = 1'b0;
      count_d           = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (commit) begin
      slot_out_o     <= res_slot;
      payload_out_o  <= res_pay;
      priority_out_o <= res_prio;
      occupied_o     <= res_occ;
      status_o       <= res_stat;
      if (mem_we) begin
        prio_q[free_idx] <= '0;
        rank_q[free_idx] <= count_q[SlotW-1:0];
      end
      if (do_promote) begin
        prio_q[cur_q.slot] <= prio_q[cur_q.slot] + 1'b1;
      end
      if (do_pop) begin
        for (int i = 0; i < Depth; i++) begin
          if (used_q[i] && rank_q[i] > win_q.rank) begin
            rank_q[i] <= rank_q[i] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && mem_we) begin
      pay_mem[free_idx] <= cur_q.payload;
    end
    if (mem_re) begin
      rdata_q <= pay_mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/promotable_priority_table_unit.sv -----
// Top level of the promotable priority table
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | command_i, payload_in_i, slot_in_i
//   out     | output    | out_valid_o/out_ready_i | slot_out_o, payload_out_o,
//           |           |                         | priority_out_o, occupied_o, status_o
//
// Add, promote, read, is_valid and unknown commands go from idle straight to done in the
// engine; get_max and pop_max also pass StTree1 and StTree2, for the two registered tree
// levels and the registered payload read. A two-entry queue decouples input from engine.
// Reset empties the table at once; no clearing pass is needed.
// A stalled result holds the engine; the queue keeps taking input until it fills.
module promotable_priority_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ppt_pkg::CmdW-1:0]      command_i,
  input  logic [ppt_pkg::PayloadW-1:0]  payload_in_i,
  input  logic [ppt_pkg::SlotW-1:0]     slot_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ppt_pkg::SlotW-1:0]     slot_out_o,
  output logic [ppt_pkg::PayloadW-1:0]  payload_out_o,
  output logic [ppt_pkg::PrioW-1:0]     priority_out_o,
  output logic                          occupied_o,
  output logic [ppt_pkg::StatW-1:0]     status_o
);

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  ppt_pkg::req_t req;
  ppt_pkg::req_t head;

  ppt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .payload_in_i (payload_in_i),
    .slot_in_i    (slot_in_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .req_o        (req)
  );

  ppt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  ppt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (head),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_out_o     (slot_out_o),
    .payload_out_o  (payload_out_o),
    .priority_out_o (priority_out_o),
    .occupied_o     (occupied_o),
    .status_o       (status_o)
  );

endmodule

// ----- hdl/ppt_checker.sv -----
// Port-level assertions for the priority table, bound to the top level
module ppt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ppt_pkg::SlotW-1:0]     slot_out_o,
  input logic [ppt_pkg::PayloadW-1:0]  payload_out_o,
  input logic [ppt_pkg::PrioW-1:0]     priority_out_o,
  input logic                          occupied_o,
  input logic [ppt_pkg::StatW-1:0]     status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_out_o)
      && $stable(payload_out_o) && $stable(priority_out_o)
      && $stable(occupied_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  a_occupied_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && occupied_o |-> status_o == ppt_pkg::StatOk && slot_out_o == '0
      && payload_out_o == '0 && priority_out_o == '0)
    else $error("is_valid result carries other fields");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ppt_pkg::StatOk |-> slot_out_o == '0
      && payload_out_o == '0 && priority_out_o == '0 && !occupied_o)
    else $error("error result carries data");

endmodule

bind promotable_priority_table_unit ppt_checker u_ppt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .slot_out_o     (slot_out_o),
  .payload_out_o  (payload_out_o),
  .priority_out_o (priority_out_o),
  .occupied_o     (occupied_o),
  .status_o       (status_o)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the promotable priority table unit
`timescale 1ns / 1ps

module testbench;
  import ppt_pkg::*;

  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned BurstItems  = 24;
  localparam int unsigned PhaseItems  = 480;
  localparam int unsigned TailCycles  = 40;
  localparam int          DirectedRows = 25;

  typedef struct packed {
    logic [SlotW-1:0]    slot;
    logic [PayloadW-1:0] payload;
    logic [PrioW-1:0]    prio;
    logic                occupied;
    logic [StatW-1:0]    status;
  } table_result_t;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [PayloadW-1:0] payload;
    logic [SlotW-1:0]    slot;
    logic [4:0]          reps;
    logic                typed;
    table_result_t       want;
  } stim_row_t;

  localparam table_result_t ResZero   = '0;
  localparam table_result_t ResEmpty  = '{4'd0, 32'd0, 31'd0, 1'b0, StatEmpty};
  localparam table_result_t ResFull   = '{4'd0, 32'd0, 31'd0, 1'b0, StatFull};
  localparam table_result_t ResUnused = '{4'd0, 32'd0, 31'd0, 1'b0, StatUnused};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CmdW-1:0]     command_i = CmdAdd;
  logic [PayloadW-1:0] payload_in_i = '0;
  logic [SlotW-1:0]    slot_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SlotW-1:0]    slot_out_o;
  logic [PayloadW-1:0] payload_out_o;
  logic [PrioW-1:0]    priority_out_o;
  logic                occupied_o;
  logic [StatW-1:0]    status_o;

  logic                table_used    [TableDepth];
  logic [PayloadW-1:0] table_payload [TableDepth];
  logic [PrioW-1:0]    table_prio    [TableDepth];
  logic [SlotW-1:0]    table_rank    [TableDepth];
  logic [CountW-1:0]   table_count;

  table_result_t expected_results [$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  logic [7:0]    hold_tag = '0;
  logic [7:0]    hold_seen = '0;
  int unsigned   hold_left = 0;
  int unsigned   rx_cycle = 0;

  stim_row_t directed_rows [DirectedRows] = '{
    '{CmdGetMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1, ResEmpty},
    '{CmdPopMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1, ResEmpty},
    '{CmdIsValid, 32'h0000_0000, 4'd0,  5'd1,  1'b1, ResZero},
    '{CmdSpare6,  32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, ResZero},
    '{CmdSpare7,  32'h0000_0000, 4'd0,  5'd1,  1'b1, ResZero},
    '{CmdAdd,     32'h0000_0000, 4'd0,  5'd1,  1'b1, ResZero},
    '{CmdAdd,     32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, '{4'd1, 32'd0, 31'd0, 1'b0, StatOk}},
    '{CmdAdd,     32'hA5A5_A5A5, 4'd0,  5'd1,  1'b1, '{4'd2, 32'd0, 31'd0, 1'b0, StatOk}},
    '{CmdGetMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1,
      '{4'd2, 32'hA5A5_A5A5, 31'd0, 1'b0, StatOk}},
    '{CmdPromote, 32'h0000_0000, 4'd0,  5'd1,  1'b1, ResZero},
    '{CmdGetMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1, '{4'd0, 32'd0, 31'd1, 1'b0, StatOk}},
    '{CmdRead,    32'h0000_0000, 4'd1,  5'd1,  1'b1,
      '{4'd0, 32'hFFFF_FFFF, 31'd0, 1'b0, StatOk}},
    '{CmdIsValid, 32'h0000_0000, 4'd1,  5'd1,  1'b1, '{4'd0, 32'd0, 31'd0, 1'b1, StatOk}},
    '{CmdPopMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1, '{4'd0, 32'd0, 31'd1, 1'b0, StatOk}},
    '{CmdRead,    32'h0000_0000, 4'd0,  5'd1,  1'b1, ResUnused},
    '{CmdPromote, 32'h0000_0000, 4'd0,  5'd1,  1'b1, ResUnused},
    '{CmdAdd,     32'h5A5A_5A5A, 4'd0,  5'd1,  1'b1, ResZero},
    '{CmdPopMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1,
      '{4'd0, 32'h5A5A_5A5A, 31'd0, 1'b0, StatOk}},
    '{CmdAdd,     32'h3C3C_0000, 4'd0,  5'd14, 1'b0, ResZero},
    '{CmdAdd,     32'h1234_5678, 4'd0,  5'd1,  1'b1, ResFull},
    '{CmdPromote, 32'h0000_0000, 4'd15, 5'd3,  1'b0, ResZero},
    '{CmdRead,    32'h0000_0000, 4'd15, 5'd1,  1'b0, ResZero},
    '{CmdPopMax,  32'h0000_0000, 4'd0,  5'd16, 1'b0, ResZero},
    '{CmdGetMax,  32'h0000_0000, 4'd0,  5'd1,  1'b1, ResEmpty},
    '{CmdIsValid, 32'h0000_0000, 4'd15, 5'd1,  1'b1, ResZero}
  };

  promotable_priority_table_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .payload_in_i   (payload_in_i),
    .slot_in_i      (slot_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_out_o     (slot_out_o),
    .payload_out_o  (payload_out_o),
    .priority_out_o (priority_out_o),
    .occupied_o     (occupied_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic table_result_t table_apply(input logic [CmdW-1:0]     cmd,
                                                input logic [PayloadW-1:0] payload,
                                                input logic [SlotW-1:0]    slot);
    table_result_t r;
    int free_slot;
    int best;
    r = '0;
    free_slot = -1;
    best = -1;
    case (cmd)
      CmdAdd: begin
        for (int i = TableDepth - 1; i >= 0; i--) if (!table_used[i]) free_slot = i;
        if (table_count >= TableDepth || free_slot < 0) begin
          r.status = StatFull;
        end else begin
          table_used[free_slot]    = 1'b1;
          table_payload[free_slot] = payload;
          table_prio[free_slot]    = '0;
          table_rank[free_slot]    = table_count[SlotW-1:0];
          table_count++;
          r.slot = free_slot[SlotW-1:0];
        end
      end
      CmdPromote: begin
        if (!table_used[slot]) r.status = StatUnused;
        else if (table_prio[slot] != PrioMax) table_prio[slot]++;
      end
      CmdRead: begin
        if (!table_used[slot]) r.status = StatUnused;
        else r.payload = table_payload[slot];
      end
      CmdIsValid: r.occupied = table_used[slot];
      CmdGetMax, CmdPopMax: begin
        if (table_count == 0) begin
          r.status = StatEmpty;
        end else begin
          for (int i = 0; i < TableDepth; i++) begin
            if (table_used[i] && (best < 0 || table_prio[i] > table_prio[best] ||
                (table_prio[i] == table_prio[best] && table_rank[i] > table_rank[best])))
              best = i;
          end
          r.slot    = best[SlotW-1:0];
          r.payload = table_payload[best];
          r.prio    = table_prio[best];
          if (cmd == CmdPopMax) begin
            for (int i = 0; i < TableDepth; i++)
              if (table_used[i] && table_rank[i] > table_rank[best]) table_rank[i]--;
            table_used[best] = 1'b0;
            table_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic offer(input logic [CmdW-1:0] cmd, input logic [PayloadW-1:0] payload,
                       input logic [SlotW-1:0] slot, input logic typed,
                       input table_result_t typed_result);
    table_result_t predicted;
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    payload_in_i <= payload;
    slot_in_i    <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = table_apply(cmd, payload, slot);
    expected_results.insert(expected_results.size(), typed ? typed_result : predicted);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic await_drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_item(input logic filling, output logic [CmdW-1:0] cmd,
                             output logic [PayloadW-1:0] payload,
                             output logic [SlotW-1:0] slot);
    int unsigned roll;
    int unsigned cuts [6];
    roll    = $urandom_range(99);
    payload = $urandom();
    if (filling) cuts = '{35, 60, 68, 76, 84, 96};
    else cuts = '{10, 30, 38, 46, 56, 96};
    if (roll < cuts[0]) cmd = CmdAdd;
    else if (roll < cuts[1]) cmd = CmdPromote;
    else if (roll < cuts[2]) cmd = CmdRead;
    else if (roll < cuts[3]) cmd = CmdIsValid;
    else if (roll < cuts[4]) cmd = CmdGetMax;
    else if (roll < cuts[5]) cmd = CmdPopMax;
    else cmd = roll[0] ? CmdSpare7 : CmdSpare6;
    slot = SlotW'($urandom_range(TableDepth - 1));
    if (table_count != 0 && $urandom_range(99) < 80)
      while (!table_used[slot]) slot = SlotW'($urandom_range(TableDepth - 1));
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned items, inout logic filling);
    logic [CmdW-1:0]     cmd;
    logic [PayloadW-1:0] payload;
    logic [SlotW-1:0]    slot;
    receiver_stall_pct = rx_pct;
    for (int n = 0; n < items; n++) begin
      if (table_count == TableDepth && $urandom_range(3) == 0) filling = 1'b0;
      if (table_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      if ($urandom_range(79) == 0) filling = ~filling;
      sender_idle_pct = (n % 100 < 15) ? 0 : tx_pct;
      random_item(filling, cmd, payload, slot);
      offer(cmd, payload, slot, 1'b0, ResZero);
      sender_gap();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[promotable_priority_table_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_tag != hold_seen) begin
      hold_seen   <= hold_tag;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (rx_cycle % 150 < 20) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0h payload %0h",
                 $time, slot_out_o, payload_out_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("slot_out", 32'(want.slot), 32'(slot_out_o));
        check_field("payload_out", want.payload, payload_out_o);
        check_field("priority_out", 32'(want.prio), 32'(priority_out_o));
        check_field("occupied", 32'(want.occupied), 32'(occupied_o));
        check_field("status", 32'(want.status), 32'(status_o));
      end
    end
  end

  initial begin
    logic filling;
    logic [CmdW-1:0]     cmd;
    logic [PayloadW-1:0] payload;
    logic [SlotW-1:0]    slot;
    rst_ni      <= 1'b0;
    filling     = 1'b1;
    table_count = '0;
    for (int i = 0; i < TableDepth; i++) begin
      table_used[i]    = 1'b0;
      table_payload[i] = '0;
      table_prio[i]    = '0;
      table_rank[i]    = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    receiver_stall_pct = 0;
    sender_idle_pct    = 0;
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        offer(directed_rows[r].cmd, directed_rows[r].payload + k, directed_rows[r].slot,
              directed_rows[r].typed, directed_rows[r].want);
    end
    await_drain();

    run_phase(0, 0, PhaseItems, filling);

    // stall the output long enough for the input to back up
    hold_tag <= hold_tag + 1;
    sender_idle_pct = 0;
    for (int n = 0; n < BurstItems; n++) begin
      random_item(1'b1, cmd, payload, slot);
      offer(cmd, payload, slot, 1'b0, ResZero);
    end
    await_drain();

    run_phase(77, 0, PhaseItems, filling);
    run_phase(0, 77, PhaseItems, filling);
    run_phase(11, 11, PhaseItems, filling);

    await_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[promotable_priority_table_unit] OK");
    end else begin
      $display("[promotable_priority_table_unit] ERROR");
    end
    $finish;
  end

endmodule
